// ===== sv/cclr_pkg.sv =====
// shared lane indexes, register indexes and term tables for the laser rhs pipeline
package cclr_pkg;

    localparam int NUM_LANES = 10;
    localparam int NUM_TERMS = 5;
    localparam int CFG_IDX_BITS = 3;

    // lane order follows the state and tangent vector order
    localparam int IX_EX = 0;
    localparam int IX_EY = 1;
    localparam int IX_P1 = 2;
    localparam int IX_P2 = 3;
    localparam int IX_N  = 4;
    localparam int IX_A  = 5;
    localparam int IX_B  = 6;
    localparam int IX_C  = 7;
    localparam int IX_D  = 8;
    localparam int IX_E  = 9;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DETUNING    = 3'd0,
        CFG_POL_DECAY   = 3'd1,
        CFG_INV_DECAY   = 3'd2,
        CFG_PUMP_LEVEL  = 3'd3,
        CFG_TIME_SCALE  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FAC_ONE,
        FAC_POL,
        FAC_INV
    } t_factor;

    typedef logic [NUM_TERMS-1:0] t_term_mask;

    // bit t set: term t of the lane is subtracted
    localparam t_term_mask TERM_SUB [NUM_LANES] = '{
        5'b00111,
        5'b00001,
        5'b00001,
        5'b00111,
        5'b01010,
        5'b00111,
        5'b00010,
        5'b00010,
        5'b01111,
        5'b10110
    };

    localparam t_factor LANE_FACTOR [NUM_LANES] = '{
        FAC_ONE, FAC_ONE, FAC_POL, FAC_POL, FAC_INV,
        FAC_ONE, FAC_ONE, FAC_POL, FAC_POL, FAC_INV
    };

endpackage

// ===== sv/cclr_prod.sv =====
// product stage: forms every term of the ten inner sums at double precision
module cclr_prod
    import cclr_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [W-1:0] i_x [NUM_LANES],
    input  logic signed [W-1:0] i_dp,
    input  logic signed [W-1:0] i_pump,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [2*W-1:0] o_term [NUM_LANES][NUM_TERMS]
);
    localparam int TW = 2 * W;

    logic                  r_v;
    logic signed [TW-1:0]  r_term [NUM_LANES][NUM_TERMS];
    logic signed [TW-1:0]  n_term [NUM_LANES][NUM_TERMS];

    function automatic logic signed [TW-1:0] scl(input logic signed [W-1:0] a);
        logic signed [TW-1:0] e;
        e = {{W{a[W-1]}}, a};
        return e <<< F;
    endfunction

    function automatic logic signed [TW-1:0] mul(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [TW-1:0] ea;
        logic signed [TW-1:0] eb;
        ea = {{W{a[W-1]}}, a};
        eb = {{W{b[W-1]}}, b};
        return ea * eb;
    endfunction

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            for (int t = 0; t < NUM_TERMS; t++) begin
                n_term[l][t] = '0;
            end
        end
        n_term[IX_EX][0] = scl(i_x[IX_EX]);
        n_term[IX_EX][1] = mul(i_dp, i_x[IX_EY]);
        n_term[IX_EX][2] = scl(i_x[IX_P2]);

        n_term[IX_EY][0] = scl(i_x[IX_EY]);
        n_term[IX_EY][1] = mul(i_dp, i_x[IX_EX]);
        n_term[IX_EY][2] = scl(i_x[IX_P1]);

        n_term[IX_P1][0] = scl(i_x[IX_P1]);
        n_term[IX_P1][1] = mul(i_dp, i_x[IX_P2]);
        n_term[IX_P1][2] = mul(i_x[IX_EY], i_x[IX_N]);

        n_term[IX_P2][0] = scl(i_x[IX_P2]);
        n_term[IX_P2][1] = mul(i_dp, i_x[IX_P1]);
        n_term[IX_P2][2] = mul(i_x[IX_EX], i_x[IX_N]);

        n_term[IX_N][0] = scl(i_pump);
        n_term[IX_N][1] = scl(i_x[IX_N]);
        n_term[IX_N][2] = mul(i_x[IX_P2], i_x[IX_EX]);
        n_term[IX_N][3] = mul(i_x[IX_P1], i_x[IX_EY]);

        n_term[IX_A][0] = scl(i_x[IX_A]);
        n_term[IX_A][1] = mul(i_dp, i_x[IX_B]);
        n_term[IX_A][2] = scl(i_x[IX_D]);

        n_term[IX_B][0] = mul(i_dp, i_x[IX_A]);
        n_term[IX_B][1] = scl(i_x[IX_B]);
        n_term[IX_B][2] = scl(i_x[IX_C]);

        n_term[IX_C][0] = mul(i_x[IX_N], i_x[IX_B]);
        n_term[IX_C][1] = scl(i_x[IX_C]);
        n_term[IX_C][2] = mul(i_dp, i_x[IX_D]);
        n_term[IX_C][3] = mul(i_x[IX_EY], i_x[IX_E]);

        n_term[IX_D][0] = mul(i_x[IX_N], i_x[IX_A]);
        n_term[IX_D][1] = mul(i_dp, i_x[IX_C]);
        n_term[IX_D][2] = scl(i_x[IX_D]);
        n_term[IX_D][3] = mul(i_x[IX_EX], i_x[IX_E]);

        n_term[IX_E][0] = mul(i_x[IX_P2], i_x[IX_A]);
        n_term[IX_E][1] = mul(i_x[IX_P1], i_x[IX_B]);
        n_term[IX_E][2] = mul(i_x[IX_EY], i_x[IX_C]);
        n_term[IX_E][3] = mul(i_x[IX_EX], i_x[IX_D]);
        n_term[IX_E][4] = scl(i_x[IX_E]);
    end

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_term  = r_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_term <= n_term;
        end
    end

endmodule

// ===== sv/cclr_sum.sv =====
// sum stage: adds the signed terms of each lane, then truncates and saturates
module cclr_sum
    import cclr_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [2*W-1:0] i_term [NUM_LANES][NUM_TERMS],
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [W-1:0]   o_word [NUM_LANES]
);
    localparam int TW = 2 * W;
    localparam int SW = TW + 3;
    localparam int HW = SW - F;

    logic                 r_v_a;
    logic                 r_v_b;
    logic                 rdy_a;
    logic                 rdy_b;
    logic signed [SW-1:0] r_sum  [NUM_LANES];
    logic signed [SW-1:0] n_sum  [NUM_LANES];
    logic signed [W-1:0]  r_word [NUM_LANES];
    logic signed [W-1:0]  n_word [NUM_LANES];

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            n_sum[l] = '0;
            for (int t = 0; t < NUM_TERMS; t++) begin
                if (TERM_SUB[l][t]) begin
                    n_sum[l] = n_sum[l] - SW'(i_term[l][t]);
                end else begin
                    n_sum[l] = n_sum[l] + SW'(i_term[l][t]);
                end
            end
        end
    end

    // floor by the fraction bits, clamp to the word range
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            if (r_sum[l][SW-1:W-1+F] != {(HW-W+1){r_sum[l][SW-1]}}) begin
                n_word[l] = r_sum[l][SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end else begin
                n_word[l] = r_sum[l][W-1+F:F];
            end
        end
    end

    assign rdy_b   = !r_v_b || i_ready;
    assign rdy_a   = !r_v_a || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_v_b;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_v_a <= i_valid;
            end
            if (rdy_b) begin
                r_v_b <= r_v_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_sum <= n_sum;
        end
        if (rdy_b && r_v_a) begin
            r_word <= n_word;
        end
    end

endmodule

// ===== sv/cclr_scale.sv =====
// scale stage: multiplies each lane by an unsigned factor, then truncates and saturates
module cclr_scale
    import cclr_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [W-1:0] i_word [NUM_LANES],
    input  logic [W-2:0]        i_factor [NUM_LANES],
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [W-1:0] o_word [NUM_LANES]
);
    localparam int TW = 2 * W;

    logic                 r_v_a;
    logic                 r_v_b;
    logic                 rdy_a;
    logic                 rdy_b;
    logic signed [TW-1:0] r_prod [NUM_LANES];
    logic signed [TW-1:0] n_prod [NUM_LANES];
    logic signed [W-1:0]  r_word [NUM_LANES];
    logic signed [W-1:0]  n_word [NUM_LANES];

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            n_prod[l] = TW'($signed({1'b0, i_factor[l]})) * TW'(i_word[l]);
        end
    end

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            if (r_prod[l][TW-1:W-1+F] != {(TW-W-F+1){r_prod[l][TW-1]}}) begin
                n_word[l] = r_prod[l][TW-1] ? {1'b1, {(W-1){1'b0}}}
                                            : {1'b0, {(W-1){1'b1}}};
            end else begin
                n_word[l] = r_prod[l][W-1+F:F];
            end
        end
    end

    assign rdy_b   = !r_v_b || i_ready;
    assign rdy_a   = !r_v_a || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_v_b;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_v_a <= i_valid;
            end
            if (rdy_b) begin
                r_v_b <= r_v_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_prod <= n_prod;
        end
        if (rdy_b && r_v_a) begin
            r_word <= n_word;
        end
    end

endmodule

// ===== sv/class_c_laser_rhs_with_tangent.sv =====
// top level: class c laser right-hand side with tangent, seven-stage pipeline
// throughput: one beat per cycle; each stage holds under back-pressure and bubbles close up
// one product register, then two registers each in the sum, ratio and scale stages
// reset: synchronous, active low; clears all stage valids and restores the default registers
// the configuration port is always ready
module class_c_laser_rhs_with_tangent
    import cclr_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [WORD_BITS-1:0]        i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [WORD_BITS-1:0] i_field_re,
    input  logic signed [WORD_BITS-1:0] i_field_im,
    input  logic signed [WORD_BITS-1:0] i_polar_re,
    input  logic signed [WORD_BITS-1:0] i_polar_im,
    input  logic signed [WORD_BITS-1:0] i_inversion,
    input  logic signed [WORD_BITS-1:0] i_tan_field_re,
    input  logic signed [WORD_BITS-1:0] i_tan_field_im,
    input  logic signed [WORD_BITS-1:0] i_tan_polar_re,
    input  logic signed [WORD_BITS-1:0] i_tan_polar_im,
    input  logic signed [WORD_BITS-1:0] i_tan_inversion,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [WORD_BITS-1:0] o_d_field_re,
    output logic signed [WORD_BITS-1:0] o_d_field_im,
    output logic signed [WORD_BITS-1:0] o_d_polar_re,
    output logic signed [WORD_BITS-1:0] o_d_polar_im,
    output logic signed [WORD_BITS-1:0] o_d_inversion,
    output logic signed [WORD_BITS-1:0] o_d_tan_field_re,
    output logic signed [WORD_BITS-1:0] o_d_tan_field_im,
    output logic signed [WORD_BITS-1:0] o_d_tan_polar_re,
    output logic signed [WORD_BITS-1:0] o_d_tan_polar_im,
    output logic signed [WORD_BITS-1:0] o_d_tan_inversion
);
    localparam int W = WORD_BITS;
    localparam int F = FRAC_BITS;
    localparam logic [W-2:0] ONE = (W-1)'(1) << F;

    logic signed [W-1:0] r_detuning;
    logic [W-2:0]        r_pol_decay;
    logic [W-2:0]        r_inv_decay;
    logic signed [W-1:0] r_pump_level;
    logic [W-2:0]        r_time_scale;

    logic signed [W-1:0]   s_x      [NUM_LANES];
    logic signed [2*W-1:0] s_term   [NUM_LANES][NUM_TERMS];
    logic signed [W-1:0]   s_inner  [NUM_LANES];
    logic signed [W-1:0]   s_ratio  [NUM_LANES];
    logic signed [W-1:0]   s_out    [NUM_LANES];
    logic [W-2:0]          s_rfac   [NUM_LANES];
    logic [W-2:0]          s_sfac   [NUM_LANES];
    logic s_prod_valid, s_prod_ready;
    logic s_sum_valid, s_sum_ready;
    logic s_ratio_valid, s_ratio_ready;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detuning   <= '0;
            r_pol_decay  <= ONE;
            r_inv_decay  <= ONE;
            r_pump_level <= '0;
            r_time_scale <= ONE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DETUNING:   r_detuning   <= i_cfg_data;
                CFG_POL_DECAY:  r_pol_decay  <= i_cfg_data[W-2:0];
                CFG_INV_DECAY:  r_inv_decay  <= i_cfg_data[W-2:0];
                CFG_PUMP_LEVEL: r_pump_level <= i_cfg_data;
                CFG_TIME_SCALE: r_time_scale <= i_cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    assign s_x[IX_EX] = i_field_re;
    assign s_x[IX_EY] = i_field_im;
    assign s_x[IX_P1] = i_polar_re;
    assign s_x[IX_P2] = i_polar_im;
    assign s_x[IX_N]  = i_inversion;
    assign s_x[IX_A]  = i_tan_field_re;
    assign s_x[IX_B]  = i_tan_field_im;
    assign s_x[IX_C]  = i_tan_polar_re;
    assign s_x[IX_D]  = i_tan_polar_im;
    assign s_x[IX_E]  = i_tan_inversion;

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            s_sfac[l] = r_time_scale;
            case (LANE_FACTOR[l])
                FAC_POL: s_rfac[l] = r_pol_decay;
                FAC_INV: s_rfac[l] = r_inv_decay;
                default: s_rfac[l] = ONE;
            endcase
        end
    end

    cclr_prod #(.W(W), .F(F)) u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_x     (s_x),
        .i_dp    (r_detuning),
        .i_pump  (r_pump_level),
        .o_valid (s_prod_valid),
        .i_ready (s_prod_ready),
        .o_term  (s_term)
    );

    cclr_sum #(.W(W), .F(F)) u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_prod_valid),
        .o_ready (s_prod_ready),
        .i_term  (s_term),
        .o_valid (s_sum_valid),
        .i_ready (s_sum_ready),
        .o_word  (s_inner)
    );

    cclr_scale #(.W(W), .F(F)) u_ratio (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_sum_valid),
        .o_ready  (s_sum_ready),
        .i_word   (s_inner),
        .i_factor (s_rfac),
        .o_valid  (s_ratio_valid),
        .i_ready  (s_ratio_ready),
        .o_word   (s_ratio)
    );

    cclr_scale #(.W(W), .F(F)) u_tscale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_ratio_valid),
        .o_ready  (s_ratio_ready),
        .i_word   (s_ratio),
        .i_factor (s_sfac),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_word   (s_out)
    );

    assign o_d_field_re      = s_out[IX_EX];
    assign o_d_field_im      = s_out[IX_EY];
    assign o_d_polar_re      = s_out[IX_P1];
    assign o_d_polar_im      = s_out[IX_P2];
    assign o_d_inversion     = s_out[IX_N];
    assign o_d_tan_field_re  = s_out[IX_A];
    assign o_d_tan_field_im  = s_out[IX_B];
    assign o_d_tan_polar_re  = s_out[IX_C];
    assign o_d_tan_polar_im  = s_out[IX_D];
    assign o_d_tan_inversion = s_out[IX_E];

    a_reset_defaults: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_time_scale == ONE && r_pol_decay == ONE && r_inv_decay == ONE
                      && r_detuning == '0 && r_pump_level == '0))
        else $error("configuration registers not at defaults after reset");

    a_scale_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_index == CFG_TIME_SCALE
        |=> r_time_scale == $past(i_cfg_data[W-2:0]))
        else $error("time scale write lost");

    a_unknown_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_index != CFG_DETUNING && i_cfg_index != CFG_POL_DECAY
        && i_cfg_index != CFG_INV_DECAY && i_cfg_index != CFG_PUMP_LEVEL
        && i_cfg_index != CFG_TIME_SCALE
        |=> $stable(r_detuning) && $stable(r_pol_decay) && $stable(r_inv_decay)
            && $stable(r_pump_level) && $stable(r_time_scale))
        else $error("write to unknown index changed a register");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_ratio_valid && !s_ratio_ready |=> s_ratio_valid && $stable(s_ratio[IX_N]))
        else $error("ratio stage dropped a stalled beat");

endmodule
